// ----- src/bri_pkg.sv -----
// ----------------------------------------------------------------------------
// bri_pkg
// Shared types, constants and saturation helpers for the Bloch RK4 integrator.
// ----------------------------------------------------------------------------
package bri_pkg;

    localparam int PACKETS   = 64;
    localparam int FRAC_BITS = 16;
    localparam int PKT_AW    = (PACKETS > 1) ? $clog2(PACKETS) : 1;
    localparam int CNT_W     = PKT_AW + 1;

    // operand split for the dt/6 times bracket product
    localparam int SPLIT  = 16;
    localparam int PROD_W = 65;
    localparam int WIDE_W = 82;
    localparam int ACC_W  = 34;
    localparam int BR_W   = 35;
    localparam int SUM_W  = 32 + CNT_W + 1;

    // round(2*pi * 2^FRAC_BITS)
    localparam logic signed [31:0] TWO_PI_Q =
        32'((64'sd26986075409 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS));
    // high word of x * DIV6_MAGIC, plus one when x is negative, is x / 6 toward zero
    localparam logic signed [31:0] DIV6_MAGIC = 32'sh2AAAAAAB;

    localparam logic signed [WIDE_W-1:0] MAX32 = WIDE_W'(64'sd2147483647);
    localparam logic signed [WIDE_W-1:0] MIN32 = -MAX32 - WIDE_W'(1);
    localparam logic signed [SUM_W-1:0]  MAX40 = SUM_W'(64'sd549755813887);
    localparam logic signed [SUM_W-1:0]  MIN40 = -MAX40 - SUM_W'(1);

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [2:0] CFG_GYRO     = 3'd0;
    localparam logic [2:0] CFG_STEP     = 3'd1;
    localparam logic [2:0] CFG_INV_T1   = 3'd2;
    localparam logic [2:0] CFG_INV_T2   = 3'd3;
    localparam logic [2:0] CFG_FRAME    = 3'd4;
    localparam logic [2:0] CFG_EQ_BASE  = 3'd5;
    localparam logic [2:0] CFG_ACTIVE   = 3'd6;

    typedef struct packed {
        cmd_t               command;
        logic [5:0]         packet_index;
        logic signed [31:0] packet_ratio;
        logic signed [31:0] packet_field;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } cmd_item_t;

    typedef struct packed {
        logic signed [39:0] sum_x;
        logic signed [39:0] sum_y;
        logic signed [39:0] sum_z;
    } res_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] r;
        begin
            r = v;
            if (v > MAX32)
            begin
                r = MAX32;
            end
            else if (v < MIN32)
            begin
                r = MIN32;
            end
            return r[31:0];
        end
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        begin
            r = v;
            if (v > MAX40)
            begin
                r = MAX40;
            end
            else if (v < MIN40)
            begin
                r = MIN40;
            end
            return r[39:0];
        end
    endfunction

endpackage

// ----- src/bloch_rk4_integrator_top.sv -----
// ----------------------------------------------------------------------------
// bloch_rk4_integrator_top
// Bloch-equation RK4 integrator over a bank of spin packets, one shared
// multiplier under a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_item) takes load, start and step
//   items; res channel (res_valid / res_stall / res_item) returns the sums.
//   A load item writes one packet's ratio and field and gives no result.
//   Start and step items work through the n packets in use (64 after
//   reset). The rate is set by the single 32x33 multiplier: each packet
//   needs 51 products on a step (36 for the four derivatives, 9 for the
//   intermediate vectors, 6 for the update), each a multiply state and a
//   write-back state, plus a memory read and write.
//   cmd_stall is high from acceptance of a start or step until its result
//   has been moved into the output register. The result register holds
//   while res_stall is high; a new result waits until it is free.
//   Reset clears the control state and restores the register defaults;
//   packet memories are not cleared and must be loaded and started first.
// ----------------------------------------------------------------------------
module bloch_rk4_integrator_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  bri_pkg::cmd_item_t cmd_item,
    output logic              res_valid,
    input  logic              res_stall,
    output bri_pkg::res_item_t res_item,
    input  logic              cfg_write_en,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE_MUL,
        ST_PRE_WB,
        ST_READ,
        ST_LOAD,
        ST_MUL,
        ST_WB,
        ST_STORE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [31:0] ratio;
        logic signed [31:0] field;
    } par_t;

    typedef struct packed {
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] mz;
        logic signed [31:0] eq;
        logic signed [31:0] off;
    } pst_t;

    localparam logic [2:0] FINAL_STAGE = 3'd4;

    state_t                        state_reg;
    logic                          is_step_reg;
    logic [1:0]                    pre_reg;
    logic [2:0]                    stage_reg;
    logic [3:0]                    sub_reg;
    logic [bri_pkg::PKT_AW-1:0]    pkt_reg;
    logic [bri_pkg::CNT_W-1:0]     n_reg;

    logic signed [31:0]            gyro_reg;
    logic signed [31:0]            step_reg;
    logic signed [31:0]            inv_t1_reg;
    logic signed [31:0]            inv_t2_reg;
    logic signed [31:0]            frame_freq_reg;
    logic signed [31:0]            eq_base_reg;
    logic [6:0]                    active_reg;

    logic signed [31:0]            vec_reg [3];
    logic signed [31:0]            m_reg [3];
    logic signed [31:0]            t_reg [3];
    logic signed [31:0]            k_reg [3];
    logic signed [bri_pkg::BR_W-1:0]   br_reg [3];
    logic signed [bri_pkg::SUM_W-1:0]  sum_reg [3];
    logic signed [bri_pkg::ACC_W-1:0]  acc_reg;
    logic signed [bri_pkg::PROD_W-1:0] prod_reg;
    logic signed [bri_pkg::PROD_W-1:0] plo_reg;
    logic signed [31:0]            omx_reg;
    logic signed [31:0]            omy_reg;
    logic signed [31:0]            om0z_reg;
    logic signed [31:0]            omz_reg;
    logic signed [31:0]            frame_reg;
    logic signed [31:0]            dt6_reg;
    logic signed [31:0]            eq_reg;
    logic signed [31:0]            off_reg;
    logic signed [31:0]            ratio_reg;
    logic signed [31:0]            field_reg;
    bri_pkg::res_item_t            res_reg;
    logic                          res_valid_reg;

    par_t                          par_mem [bri_pkg::PACKETS];
    pst_t                          pst_mem [bri_pkg::PACKETS];
    par_t                          par_rd_reg;
    pst_t                          pst_rd_reg;

    logic                          cmd_fire;
    logic                          res_fire;
    logic                          par_we;
    logic [bri_pkg::CNT_W-1:0]     n_cur;
    logic                          last_pkt;
    logic                          out_free;

    logic signed [31:0]            dt_half;
    logic signed [31:0]            v_sel [3];
    logic signed [31:0]            dev_z;
    logic signed [31:0]            mul_a;
    logic signed [32:0]            mul_b;
    logic signed [31:0]            q;
    logic                          d_first;
    logic                          d_neg;
    logic                          d_last;
    logic [1:0]                    d_comp;
    logic [1:0]                    a_comp;
    logic [1:0]                    f_comp;
    logic signed [bri_pkg::ACC_W-1:0]  acc_sum;
    logic signed [31:0]            k_new;
    logic signed [bri_pkg::BR_W-1:0]   br_new;
    logic signed [bri_pkg::WIDE_W-1:0] full_inc;
    logic signed [31:0]            inc;

    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign res_fire  = res_valid_reg && !res_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;
    assign out_free  = !res_valid_reg || !res_stall;

    assign par_we = cmd_fire && (cmd_item.command == bri_pkg::CMD_LOAD)
                    && (32'(cmd_item.packet_index) < 32'(bri_pkg::PACKETS));

    assign n_cur = (32'(active_reg) > 32'(bri_pkg::PACKETS))
                   ? bri_pkg::CNT_W'(bri_pkg::PACKETS) : bri_pkg::CNT_W'(active_reg);
    assign last_pkt = (32'(pkt_reg) + 32'd1) == 32'(n_reg);

    assign dt_half = step_reg >>> 1;
    assign q = bri_pkg::sat32(bri_pkg::WIDE_W'(prod_reg >>> bri_pkg::FRAC_BITS));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_sel[i] = (stage_reg == 3'd0) ? m_reg[i] : t_reg[i];
        end
    end

    assign dev_z = bri_pkg::sat32(bri_pkg::WIDE_W'(v_sel[2]) - bri_pkg::WIDE_W'(eq_reg));

    // derivative term decode: which component, sign and position in its sum
    always_comb
    begin
        d_first = 1'b0;
        d_last  = 1'b0;
        d_neg   = 1'b1;
        d_comp  = 2'd0;
        case (sub_reg)
            4'd0:    begin d_first = 1'b1; d_neg = 1'b0; d_comp = 2'd0; end
            4'd1:    begin d_comp = 2'd0; end
            4'd2:    begin d_last = 1'b1; d_comp = 2'd0; end
            4'd3:    begin d_first = 1'b1; d_neg = 1'b0; d_comp = 2'd1; end
            4'd4:    begin d_comp = 2'd1; end
            4'd5:    begin d_last = 1'b1; d_comp = 2'd1; end
            4'd6:    begin d_first = 1'b1; d_neg = 1'b0; d_comp = 2'd2; end
            4'd7:    begin d_comp = 2'd2; end
            4'd8:    begin d_last = 1'b1; d_comp = 2'd2; end
            default: begin d_comp = 2'd0; end
        endcase
    end

    assign a_comp = 2'(sub_reg - 4'd9);
    assign f_comp = sub_reg[2:1];

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PRE_MUL, ST_PRE_WB:
            begin
                if (is_step_reg)
                begin
                    if (pre_reg == 2'd3)
                    begin
                        mul_a = bri_pkg::DIV6_MAGIC;
                        mul_b = 33'(step_reg);
                    end
                    else
                    begin
                        mul_a = gyro_reg;
                        mul_b = 33'(vec_reg[pre_reg]);
                    end
                end
                else
                begin
                    mul_a = bri_pkg::TWO_PI_Q;
                    mul_b = 33'(frame_freq_reg);
                end
            end
            ST_MUL, ST_WB:
            begin
                if (!is_step_reg)
                begin
                    mul_a = ratio_reg;
                    case (sub_reg)
                        4'd0:    mul_b = 33'(vec_reg[0]);
                        4'd1:    mul_b = 33'(vec_reg[1]);
                        4'd2:    mul_b = 33'(vec_reg[2]);
                        4'd3:    mul_b = 33'(eq_base_reg);
                        default:
                        begin
                            mul_a = gyro_reg;
                            mul_b = 33'(field_reg);
                        end
                    endcase
                end
                else if (stage_reg == FINAL_STAGE)
                begin
                    mul_a = dt6_reg;
                    mul_b = sub_reg[0] ? 33'(br_reg[f_comp] >>> bri_pkg::SPLIT)
                                       : 33'({1'b0, br_reg[f_comp][bri_pkg::SPLIT-1:0]});
                end
                else
                begin
                    case (sub_reg)
                        4'd0:    begin mul_a = v_sel[1]; mul_b = 33'(omz_reg);    end
                        4'd1:    begin mul_a = v_sel[2]; mul_b = 33'(omy_reg);    end
                        4'd2:    begin mul_a = v_sel[0]; mul_b = 33'(inv_t2_reg); end
                        4'd3:    begin mul_a = v_sel[2]; mul_b = 33'(omx_reg);    end
                        4'd4:    begin mul_a = v_sel[0]; mul_b = 33'(omz_reg);    end
                        4'd5:    begin mul_a = v_sel[1]; mul_b = 33'(inv_t2_reg); end
                        4'd6:    begin mul_a = v_sel[0]; mul_b = 33'(omy_reg);    end
                        4'd7:    begin mul_a = v_sel[1]; mul_b = 33'(omx_reg);    end
                        4'd8:    begin mul_a = dev_z;    mul_b = 33'(inv_t1_reg); end
                        default:
                        begin
                            mul_a = (stage_reg == 3'd2) ? step_reg : dt_half;
                            mul_b = 33'(k_reg[a_comp]);
                        end
                    endcase
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign acc_sum = (d_first ? bri_pkg::ACC_W'(0) : acc_reg)
                     + (d_neg ? -bri_pkg::ACC_W'(q) : bri_pkg::ACC_W'(q));
    assign k_new   = bri_pkg::sat32(bri_pkg::WIDE_W'(acc_sum));
    // rk4 weights 1, 2, 2, 1
    assign br_new  = (stage_reg == 3'd0) ? bri_pkg::BR_W'(k_new)
                     : br_reg[d_comp] + ((stage_reg == 3'd3) ? bri_pkg::BR_W'(k_new)
                                                             : (bri_pkg::BR_W'(k_new) <<< 1));
    assign full_inc = (bri_pkg::WIDE_W'(prod_reg) <<< bri_pkg::SPLIT)
                      + bri_pkg::WIDE_W'(plo_reg);
    assign inc = bri_pkg::sat32(full_inc >>> bri_pkg::FRAC_BITS);

    // packet memories
    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[bri_pkg::PKT_AW'(cmd_item.packet_index)] <= {cmd_item.packet_ratio,
                                                                 cmd_item.packet_field};
        end
        par_rd_reg <= par_mem[pkt_reg];
        if (state_reg == ST_STORE)
        begin
            pst_mem[pkt_reg] <= {m_reg[0], m_reg[1], m_reg[2], eq_reg, off_reg};
        end
        pst_rd_reg <= pst_mem[pkt_reg];
    end

    // sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            is_step_reg    <= 1'b0;
            pre_reg        <= '0;
            stage_reg      <= '0;
            sub_reg        <= '0;
            pkt_reg        <= '0;
            n_reg          <= '0;
            res_valid_reg  <= 1'b0;
            gyro_reg       <= 32'sd65536;
            step_reg       <= 32'sd65;
            inv_t1_reg     <= '0;
            inv_t2_reg     <= '0;
            frame_freq_reg <= '0;
            eq_base_reg    <= 32'sd65536;
            active_reg     <= 7'd64;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    bri_pkg::CFG_GYRO:    gyro_reg       <= cfg_data;
                    bri_pkg::CFG_STEP:    step_reg       <= cfg_data;
                    bri_pkg::CFG_INV_T1:  inv_t1_reg     <= cfg_data;
                    bri_pkg::CFG_INV_T2:  inv_t2_reg     <= cfg_data;
                    bri_pkg::CFG_FRAME:   frame_freq_reg <= cfg_data;
                    bri_pkg::CFG_EQ_BASE: eq_base_reg    <= cfg_data;
                    bri_pkg::CFG_ACTIVE:  active_reg     <= cfg_data[6:0];
                    default:              ;
                endcase
            end

            if (res_fire)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_fire && (cmd_item.command == bri_pkg::CMD_START
                                     || cmd_item.command == bri_pkg::CMD_STEP))
                    begin
                        is_step_reg <= (cmd_item.command == bri_pkg::CMD_STEP);
                        n_reg       <= n_cur;
                        pre_reg     <= '0;
                        pkt_reg     <= '0;
                        // no packets: start only echoes, step returns zero
                        state_reg   <= (n_cur == '0) ? ST_DONE : ST_PRE_MUL;
                    end
                end
                ST_PRE_MUL:
                begin
                    state_reg <= ST_PRE_WB;
                end
                ST_PRE_WB:
                begin
                    if (!is_step_reg || pre_reg == 2'd3)
                    begin
                        state_reg <= ST_READ;
                    end
                    else
                    begin
                        pre_reg   <= pre_reg + 2'd1;
                        state_reg <= ST_PRE_MUL;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    stage_reg <= '0;
                    sub_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    state_reg <= ST_MUL;
                    sub_reg   <= sub_reg + 4'd1;
                    if (!is_step_reg)
                    begin
                        if (sub_reg == 4'd4)
                        begin
                            state_reg <= ST_STORE;
                        end
                    end
                    else if (stage_reg == FINAL_STAGE)
                    begin
                        if (sub_reg == 4'd5)
                        begin
                            state_reg <= ST_STORE;
                        end
                    end
                    else if ((stage_reg == 3'd3 && sub_reg == 4'd8) || sub_reg == 4'd11)
                    begin
                        stage_reg <= stage_reg + 3'd1;
                        sub_reg   <= '0;
                    end
                end
                ST_STORE:
                begin
                    if (last_pkt)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        pkt_reg   <= pkt_reg + bri_pkg::PKT_AW'(1);
                        state_reg <= ST_READ;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= bri_pkg::PROD_W'(mul_a) * bri_pkg::PROD_W'(mul_b);

        if (cmd_fire)
        begin
            vec_reg[0] <= cmd_item.vec_x;
            vec_reg[1] <= cmd_item.vec_y;
            vec_reg[2] <= cmd_item.vec_z;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
        end

        case (state_reg)
            ST_PRE_WB:
            begin
                if (!is_step_reg)
                begin
                    frame_reg <= q;
                end
                else
                begin
                    case (pre_reg)
                        2'd0:    omx_reg  <= q;
                        2'd1:    omy_reg  <= q;
                        2'd2:    om0z_reg <= q;
                        default: dt6_reg  <= prod_reg[63:32]
                                             + 32'(step_reg[31]);
                    endcase
                end
            end
            ST_LOAD:
            begin
                if (is_step_reg)
                begin
                    m_reg[0] <= pst_rd_reg.mx;
                    m_reg[1] <= pst_rd_reg.my;
                    m_reg[2] <= pst_rd_reg.mz;
                    eq_reg   <= pst_rd_reg.eq;
                    off_reg  <= pst_rd_reg.off;
                    omz_reg  <= bri_pkg::sat32(bri_pkg::WIDE_W'(om0z_reg)
                                               + bri_pkg::WIDE_W'(pst_rd_reg.off));
                end
                else
                begin
                    ratio_reg <= par_rd_reg.ratio;
                    field_reg <= par_rd_reg.field;
                end
            end
            ST_WB:
            begin
                if (!is_step_reg)
                begin
                    case (sub_reg)
                        4'd0:    m_reg[0] <= q;
                        4'd1:    m_reg[1] <= q;
                        4'd2:    m_reg[2] <= q;
                        4'd3:    eq_reg   <= q;
                        default: off_reg  <= bri_pkg::sat32(bri_pkg::WIDE_W'(q)
                                                            - bri_pkg::WIDE_W'(frame_reg));
                    endcase
                end
                else if (stage_reg == FINAL_STAGE)
                begin
                    if (!sub_reg[0])
                    begin
                        plo_reg <= prod_reg;
                    end
                    else
                    begin
                        m_reg[f_comp] <= bri_pkg::sat32(bri_pkg::WIDE_W'(m_reg[f_comp])
                                                        + bri_pkg::WIDE_W'(inc));
                    end
                end
                else if (sub_reg < 4'd9)
                begin
                    acc_reg <= acc_sum;
                    if (d_last)
                    begin
                        k_reg[d_comp]  <= k_new;
                        br_reg[d_comp] <= br_new;
                    end
                end
                else
                begin
                    t_reg[a_comp] <= bri_pkg::sat32(bri_pkg::WIDE_W'(m_reg[a_comp])
                                                    + bri_pkg::WIDE_W'(q));
                end
            end
            ST_STORE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sum_reg[i] <= sum_reg[i] + bri_pkg::SUM_W'(m_reg[i]);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (is_step_reg)
                    begin
                        res_reg.sum_x <= bri_pkg::sat40(sum_reg[0]);
                        res_reg.sum_y <= bri_pkg::sat40(sum_reg[1]);
                        res_reg.sum_z <= bri_pkg::sat40(sum_reg[2]);
                    end
                    else
                    begin
                        res_reg.sum_x <= 40'(vec_reg[0]);
                        res_reg.sum_y <= 40'(vec_reg[1]);
                        res_reg.sum_z <= 40'(vec_reg[2]);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- src/bri_checker.sv -----
// ----------------------------------------------------------------------------
// bri_checker
// Port-level checks for the Bloch RK4 integrator, bound to the top level.
// ----------------------------------------------------------------------------
module bri_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input bri_pkg::cmd_item_t cmd_item,
    input logic               res_valid,
    input logic               res_stall,
    input bri_pkg::res_item_t res_item
);

    // a held result keeps its value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("result changed while stalled");

    // start and step items keep the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd_item.command == bri_pkg::CMD_START
                                    || cmd_item.command == bri_pkg::CMD_STEP)
        |=> cmd_stall)
        else $error("block ready right after a start or step item");

    // a load item produces no result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && !res_valid && cmd_item.command == bri_pkg::CMD_LOAD
        |=> !res_valid)
        else $error("result after a load item");

    // a result appears only as the block becomes ready again
    a_res_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !cmd_stall && $past(cmd_stall))
        else $error("result without finishing an item");

endmodule

bind bloch_rk4_integrator_top bri_checker u_bri_checker (.*);
